@@ rtl/iwm_pkg.sv @@
// Shared types, constants and state encodings for the pixel warp mapper.
`default_nettype none

package iwm_pkg;

    localparam int COORD_BITS = 12;
    localparam int CFG_BITS   = 13;
    localparam int COUNT_BITS = 5;
    localparam int DIV_BITS   = 88;
    localparam int WIDE_BITS  = 64;

    localparam logic [CFG_BITS-1:0] COORD_LIMIT = CFG_BITS'(1 << COORD_BITS);

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_POINT_COUNT  = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_MAP  = 1'b1;

    localparam logic [DIV_BITS-1:0]  RECIP_NUM   = DIV_BITS'(1) << 56;
    localparam logic [WIDE_BITS-1:0] LIMIT_NONE  = '1;
    localparam logic [WIDE_BITS-1:0] LIMIT_MAP   = 64'h0000_0000_7FFF_FFFF;
    localparam logic [WIDE_BITS-1:0] LIMIT_WEIGHT = 64'h0000_0000_8000_0000;

    typedef struct packed {
        logic                  mode;
        logic [3:0]            point_index;
        logic [COORD_BITS-1:0] coord_x;
        logic [COORD_BITS-1:0] coord_y;
        logic [COORD_BITS-1:0] target_x;
        logic [COORD_BITS-1:0] target_y;
        logic [31:0]           pixel_rgba;
    } in_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] dest_x;
        logic [COORD_BITS-1:0] dest_y;
        logic [31:0]           dest_rgba;
    } out_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] tx;
        logic [COORD_BITS-1:0] ty;
    } point_t;

    typedef struct packed {
        logic                  start;
        logic                  round;
        logic [DIV_BITS-1:0]   dividend;
        logic [WIDE_BITS-1:0]  divisor;
        logic [WIDE_BITS-1:0]  limit;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [WIDE_BITS-1:0]  quotient;
    } div_rsp_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FIN
    } div_state_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_R_RD,
        S_R_D2,
        S_R_DIV,
        S_F_RD,
        S_F_PJ,
        S_F_KRD,
        S_F_KMUL,
        S_F_KACC,
        S_F_MUL,
        S_F_DET,
        S_F_TST,
        S_F_TDIV,
        S_F_FMUL,
        S_F_FRND,
        S_F_RDIV,
        S_F_WST,
        S_F_WDIV,
        S_F_WMUL,
        S_F_FIN,
        S_OUT
    } seq_state_t;

endpackage

`default_nettype wire

@@ rtl/iwm_point_mem.sv @@
// Control point table: one write port, one registered read port.
`default_nettype none

module iwm_point_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire iwm_pkg::point_t wr_data,
    input  wire logic [AW-1:0]   rd_addr,
    output iwm_pkg::point_t      rd_data
);
    import iwm_pkg::*;

    point_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/iwm_divider.sv @@
// Iterative restoring divider with optional round half up and saturation.
`default_nettype none

module iwm_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire iwm_pkg::div_req_t req,
    output iwm_pkg::div_rsp_t rsp
);
    import iwm_pkg::*;

    div_state_t           state_reg, state_next;
    logic [6:0]           cnt_reg;
    logic [DIV_BITS-1:0]  num_reg;
    logic [DIV_BITS-1:0]  quo_reg;
    logic [WIDE_BITS-1:0] rem_reg;
    logic [WIDE_BITS-1:0] den_reg;
    logic [WIDE_BITS-1:0] lim_reg;
    logic                 rnd_reg;
    logic [WIDE_BITS-1:0] q_reg;
    logic                 done_reg;

    logic [WIDE_BITS:0]   rem_sh;
    logic                 ge;
    logic [WIDE_BITS:0]   rem_sub;
    logic                 over;
    logic                 rup;
    logic [WIDE_BITS:0]   qinc;
    logic [WIDE_BITS-1:0] q_final;

    assign rem_sh  = {rem_reg, num_reg[DIV_BITS-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign over    = quo_reg > {{(DIV_BITS-WIDE_BITS){1'b0}}, lim_reg};
    assign rup     = rnd_reg && ({rem_reg, 1'b0} >= {1'b0, den_reg});
    assign qinc    = {1'b0, quo_reg[WIDE_BITS-1:0]} + (WIDE_BITS+1)'(rup);
    assign q_final = over ? lim_reg :
                     (qinc > {1'b0, lim_reg}) ? lim_reg : qinc[WIDE_BITS-1:0];

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (req.start)
                begin
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (cnt_reg == 7'(DIV_BITS - 1))
                begin
                    state_next = DIV_FIN;
                end
            end
            DIV_FIN:
            begin
                state_next = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == DIV_FIN);
            if (state_reg == DIV_RUN)
            begin
                cnt_reg <= cnt_reg + 7'd1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DIV_IDLE && req.start)
        begin
            num_reg <= req.dividend;
            den_reg <= req.divisor;
            lim_reg <= req.limit;
            rnd_reg <= req.round;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (state_reg == DIV_RUN)
        begin
            num_reg <= {num_reg[DIV_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_BITS-2:0], ge};
            rem_reg <= ge ? rem_sub[WIDE_BITS-1:0] : rem_sh[WIDE_BITS-1:0];
        end
        if (state_reg == DIV_FIN)
        begin
            q_reg <= q_final;
        end
    end

endmodule

`default_nettype wire

@@ rtl/idw_pixel_warp_mapper.sv @@
// Top level: configuration, sequencer and arithmetic of the pixel warp mapper.
//
//   channel   direction  handshake             payload
//   in        into       in_valid / in_stall   in_data  (in_item_t)
//   out       out of     out_valid / out_stall out_data (out_item_t)
//   cfg       into       cfg_write             cfg_index, cfg_data
//
// A load transfer is written into the table while idle. A pixel first sums the
// reciprocal distances and then works through each point: the 88-step
// shared divider (four map entries, reciprocal, weight) sets most of the
// work; a degenerate fit skips the four map divisions.
// State S_F_FIN then rounds the result and state S_OUT hands it over.
// Reset sets width and height to 512 and the point count to 0; the table is
// undefined until loaded. in_stall stays high while a pixel is in work; one
// result waits in the output register while the next transfer is taken.
`default_nettype none

module idw_pixel_warp_mapper #(
    parameter int MAX_POINTS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire iwm_pkg::in_item_t         in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output iwm_pkg::out_item_t             out_data,
    input  wire logic                      cfg_write,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [iwm_pkg::CFG_BITS-1:0] cfg_data
);
    import iwm_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam int A00 = 0;
    localparam int A01 = 1;
    localparam int A11 = 2;
    localparam int B00 = 3;
    localparam int B01 = 4;
    localparam int B10 = 5;
    localparam int B11 = 6;

    function automatic logic signed [32:0] round16(input logic signed [47:0] v);
        logic [47:0] mag;
        logic [31:0] r;
        mag = v[47] ? 48'(-v) : 48'(v);
        r   = 32'((mag + 48'd32768) >> 16);
        return v[47] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

    function automatic logic signed [25:0] round39(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [24:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        r   = 25'((mag + (64'd1 << 38)) >> 39);
        return v[63] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

    seq_state_t             state_reg, state_next;
    logic [CFG_BITS-1:0]    width_reg, height_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [CW-1:0]          n_reg, j_reg, k_reg;
    logic [3:0]             step_reg;
    logic [1:0]             e_reg;

    logic [COORD_BITS-1:0]  px_reg, py_reg;
    logic [31:0]            rgba_reg;
    point_t                 pj_reg;
    logic signed [12:0]     dxp_reg, dyp_reg;
    logic [24:0]            d2_reg;
    logic [WIDE_BITS-1:0]   rsum_reg;
    logic signed [25:0]     kp_reg [7];
    logic                   skip_reg;
    logic signed [31:0]     sum_reg [7];
    logic signed [63:0]     mul_p_reg;
    logic signed [63:0]     ms_reg [5];
    logic signed [31:0]     t_reg [4];
    logic signed [47:0]     fx_reg, fy_reg;
    logic signed [32:0]     fqx_reg, fqy_reg;
    logic [56:0]            recip_reg;
    logic [31:0]            w_reg;
    logic signed [63:0]     accx_reg, accy_reg;
    logic signed [25:0]     resx_reg, resy_reg;
    out_item_t              out_reg;
    logic                   out_valid_reg;

    logic                   in_accept;
    logic [CW-1:0]          n_eff;
    logic [6:0]             idx_ext;
    logic                   wr_en;
    point_t                 wr_data;
    logic [AW-1:0]          rd_addr;
    point_t                 rd_data;

    logic signed [12:0]     rd_dx, rd_dy;
    logic signed [25:0]     sq_x, sq_y;
    logic [24:0]            rd_d2;
    logic signed [12:0]     dk_x, dk_y, ek_x, ek_y;
    logic signed [25:0]     kp_next [7];

    logic signed [32:0]     mul_a, mul_b;
    logic signed [65:0]     mul_full;
    logic [3:0]             prev_step;
    logic [2:0]             ms_slot;
    logic [2:0]             num_slot;
    logic signed [63:0]     num_sel;
    logic [63:0]            num_mag;
    logic                   last_j;
    logic [CFG_BITS-1:0]    wlim, hlim;
    logic                   emit;
    logic                   can_load;

    div_req_t               div_req;
    div_rsp_t               div_rsp;

    iwm_point_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_ext[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    iwm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign n_eff   = (32'(count_reg) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(count_reg);
    assign idx_ext = 7'(in_data.point_index);
    assign wr_en   = in_accept && (in_data.mode == MODE_LOAD) && (32'(idx_ext) < MAX_POINTS);
    assign wr_data = '{sx: in_data.coord_x, sy: in_data.coord_y,
                       tx: in_data.target_x, ty: in_data.target_y};
    assign rd_addr = (state_reg == S_F_KRD) ? k_reg[AW-1:0] : j_reg[AW-1:0];

    assign rd_dx = $signed({1'b0, px_reg}) - $signed({1'b0, rd_data.sx});
    assign rd_dy = $signed({1'b0, py_reg}) - $signed({1'b0, rd_data.sy});
    assign sq_x  = rd_dx * rd_dx;
    assign sq_y  = rd_dy * rd_dy;
    assign rd_d2 = sq_x[24:0] + sq_y[24:0];

    assign dk_x = $signed({1'b0, rd_data.sx}) - $signed({1'b0, pj_reg.sx});
    assign dk_y = $signed({1'b0, rd_data.sy}) - $signed({1'b0, pj_reg.sy});
    assign ek_x = $signed({1'b0, rd_data.tx}) - $signed({1'b0, pj_reg.tx});
    assign ek_y = $signed({1'b0, rd_data.ty}) - $signed({1'b0, pj_reg.ty});
    assign kp_next[A00] = dk_x * dk_x;
    assign kp_next[A01] = dk_x * dk_y;
    assign kp_next[A11] = dk_y * dk_y;
    assign kp_next[B00] = ek_x * dk_x;
    assign kp_next[B01] = ek_x * dk_y;
    assign kp_next[B10] = ek_y * dk_x;
    assign kp_next[B11] = ek_y * dk_y;

    assign prev_step = step_reg - 4'd1;
    assign ms_slot   = prev_step[3:1];
    assign num_slot  = 3'(e_reg) + 3'd1;
    assign num_sel   = ms_reg[num_slot];
    assign num_mag   = num_sel[63] ? 64'(-num_sel) : 64'(num_sel);
    assign last_j    = (j_reg == n_reg - CW'(1));

    assign wlim     = (width_reg > COORD_LIMIT) ? COORD_LIMIT : width_reg;
    assign hlim     = (height_reg > COORD_LIMIT) ? COORD_LIMIT : height_reg;
    assign emit     = !resx_reg[25] && !resy_reg[25]
                      && ($unsigned(resx_reg) < 26'(wlim))
                      && ($unsigned(resy_reg) < 26'(hlim));
    assign can_load = !out_valid_reg || !out_stall;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_F_MUL:
            begin
                case (step_reg)
                    4'd0: begin mul_a = 33'(sum_reg[A00]); mul_b = 33'(sum_reg[A11]); end
                    4'd1: begin mul_a = 33'(sum_reg[A01]); mul_b = 33'(sum_reg[A01]); end
                    4'd2: begin mul_a = 33'(sum_reg[B00]); mul_b = 33'(sum_reg[A11]); end
                    4'd3: begin mul_a = 33'(sum_reg[B01]); mul_b = 33'(sum_reg[A01]); end
                    4'd4: begin mul_a = 33'(sum_reg[B01]); mul_b = 33'(sum_reg[A00]); end
                    4'd5: begin mul_a = 33'(sum_reg[B00]); mul_b = 33'(sum_reg[A01]); end
                    4'd6: begin mul_a = 33'(sum_reg[B10]); mul_b = 33'(sum_reg[A11]); end
                    4'd7: begin mul_a = 33'(sum_reg[B11]); mul_b = 33'(sum_reg[A01]); end
                    4'd8: begin mul_a = 33'(sum_reg[B11]); mul_b = 33'(sum_reg[A00]); end
                    4'd9: begin mul_a = 33'(sum_reg[B10]); mul_b = 33'(sum_reg[A01]); end
                    default: ;
                endcase
            end
            S_F_FMUL:
            begin
                case (step_reg)
                    4'd0: begin mul_a = 33'(t_reg[0]); mul_b = 33'(dxp_reg); end
                    4'd1: begin mul_a = 33'(t_reg[1]); mul_b = 33'(dyp_reg); end
                    4'd2: begin mul_a = 33'(t_reg[2]); mul_b = 33'(dxp_reg); end
                    4'd3: begin mul_a = 33'(t_reg[3]); mul_b = 33'(dyp_reg); end
                    default: ;
                endcase
            end
            S_F_WMUL:
            begin
                case (step_reg)
                    4'd0: begin mul_a = {1'b0, w_reg}; mul_b = fqx_reg; end
                    4'd1: begin mul_a = {1'b0, w_reg}; mul_b = fqy_reg; end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign mul_full = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        div_req    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && in_data.mode == MODE_MAP && n_eff != '0)
                begin
                    state_next = S_R_RD;
                end
            end
            S_R_RD:
            begin
                state_next = S_R_D2;
            end
            S_R_D2:
            begin
                if (rd_d2 == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = RECIP_NUM;
                    div_req.divisor  = 64'(rd_d2);
                    div_req.limit    = LIMIT_NONE;
                    state_next       = S_R_DIV;
                end
            end
            S_R_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = last_j ? S_F_RD : S_R_RD;
                end
            end
            S_F_RD:
            begin
                state_next = S_F_PJ;
            end
            S_F_PJ:
            begin
                state_next = S_F_KRD;
            end
            S_F_KRD:
            begin
                state_next = S_F_KMUL;
            end
            S_F_KMUL:
            begin
                state_next = S_F_KACC;
            end
            S_F_KACC:
            begin
                state_next = (k_reg == n_reg - CW'(1)) ? S_F_MUL : S_F_KRD;
            end
            S_F_MUL:
            begin
                if (step_reg == 4'd10)
                begin
                    state_next = S_F_DET;
                end
            end
            S_F_DET:
            begin
                state_next = (ms_reg[0] <= 64'sd0) ? S_F_FMUL : S_F_TST;
            end
            S_F_TST:
            begin
                div_req.start    = 1'b1;
                div_req.round    = 1'b1;
                div_req.dividend = {num_mag, 24'd0};
                div_req.divisor  = ms_reg[0];
                div_req.limit    = LIMIT_MAP;
                state_next       = S_F_TDIV;
            end
            S_F_TDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = (e_reg == 2'd3) ? S_F_FMUL : S_F_TST;
                end
            end
            S_F_FMUL:
            begin
                if (step_reg == 4'd4)
                begin
                    state_next = S_F_FRND;
                end
            end
            S_F_FRND:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = RECIP_NUM;
                div_req.divisor  = 64'(d2_reg);
                div_req.limit    = LIMIT_NONE;
                state_next       = S_F_RDIV;
            end
            S_F_RDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_F_WST;
                end
            end
            S_F_WST:
            begin
                div_req.start    = 1'b1;
                div_req.round    = 1'b1;
                div_req.dividend = {recip_reg, 31'd0};
                div_req.divisor  = rsum_reg;
                div_req.limit    = LIMIT_WEIGHT;
                state_next       = S_F_WDIV;
            end
            S_F_WDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_F_WMUL;
                end
            end
            S_F_WMUL:
            begin
                if (step_reg == 4'd2)
                begin
                    state_next = last_j ? S_F_FIN : S_F_RD;
                end
            end
            S_F_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!emit || can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            width_reg     <= CFG_BITS'(512);
            height_reg    <= CFG_BITS'(512);
            count_reg     <= '0;
            n_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            e_reg         <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= (state_next != state_reg) ? 4'd0 : step_reg + 4'd1;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    REG_POINT_COUNT:  count_reg  <= cfg_data[COUNT_BITS-1:0];
                    default: ;
                endcase
            end

            if (state_reg == S_OUT && emit && can_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        n_reg <= n_eff;
                        j_reg <= '0;
                    end
                end
                S_R_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        j_reg <= last_j ? CW'(0) : j_reg + CW'(1);
                    end
                end
                S_F_PJ:
                begin
                    k_reg <= '0;
                end
                S_F_KACC:
                begin
                    k_reg <= k_reg + CW'(1);
                end
                S_F_DET:
                begin
                    e_reg <= '0;
                end
                S_F_TDIV:
                begin
                    if (div_rsp.done)
                    begin
                        e_reg <= e_reg + 2'd1;
                    end
                end
                S_F_WMUL:
                begin
                    if (step_reg == 4'd2)
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_full[63:0];

        if (state_reg == S_OUT && emit && can_load)
        begin
            out_reg.dest_x    <= resx_reg[COORD_BITS-1:0];
            out_reg.dest_y    <= resy_reg[COORD_BITS-1:0];
            out_reg.dest_rgba <= rgba_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    px_reg   <= in_data.coord_x;
                    py_reg   <= in_data.coord_y;
                    rgba_reg <= in_data.pixel_rgba;
                    rsum_reg <= '0;
                    accx_reg <= '0;
                    accy_reg <= '0;
                end
            end
            S_R_D2:
            begin
                if (rd_d2 == '0)
                begin
                    resx_reg <= $signed({14'd0, rd_data.tx});
                    resy_reg <= $signed({14'd0, rd_data.ty});
                end
            end
            S_R_DIV:
            begin
                if (div_rsp.done)
                begin
                    rsum_reg <= rsum_reg + div_rsp.quotient;
                end
            end
            S_F_PJ:
            begin
                pj_reg  <= rd_data;
                dxp_reg <= rd_dx;
                dyp_reg <= rd_dy;
                d2_reg  <= rd_d2;
                for (int i = 0; i < 7; i++)
                begin
                    sum_reg[i] <= '0;
                end
            end
            S_F_KMUL:
            begin
                for (int i = 0; i < 7; i++)
                begin
                    kp_reg[i] <= kp_next[i];
                end
                skip_reg <= (k_reg == j_reg);
            end
            S_F_KACC:
            begin
                if (!skip_reg)
                begin
                    for (int i = 0; i < 7; i++)
                    begin
                        sum_reg[i] <= sum_reg[i] + 32'(kp_reg[i]);
                    end
                end
            end
            S_F_MUL:
            begin
                if (step_reg != 4'd0)
                begin
                    ms_reg[ms_slot] <= prev_step[0] ? ms_reg[ms_slot] - mul_p_reg : mul_p_reg;
                end
            end
            S_F_DET:
            begin
                if (ms_reg[0] <= 64'sd0)
                begin
                    t_reg[0] <= 32'sh0100_0000;
                    t_reg[1] <= '0;
                    t_reg[2] <= '0;
                    t_reg[3] <= 32'sh0100_0000;
                end
            end
            S_F_TDIV:
            begin
                if (div_rsp.done)
                begin
                    t_reg[e_reg] <= num_sel[63] ? -32'(div_rsp.quotient)
                                                : 32'(div_rsp.quotient);
                end
            end
            S_F_FMUL:
            begin
                case (prev_step)
                    4'd0: fx_reg <= mul_p_reg[47:0] + $signed({12'd0, pj_reg.tx, 24'd0});
                    4'd1: fx_reg <= fx_reg + mul_p_reg[47:0];
                    4'd2: fy_reg <= mul_p_reg[47:0] + $signed({12'd0, pj_reg.ty, 24'd0});
                    4'd3: fy_reg <= fy_reg + mul_p_reg[47:0];
                    default: ;
                endcase
            end
            S_F_FRND:
            begin
                fqx_reg <= round16(fx_reg);
                fqy_reg <= round16(fy_reg);
            end
            S_F_RDIV:
            begin
                if (div_rsp.done)
                begin
                    recip_reg <= div_rsp.quotient[56:0];
                end
            end
            S_F_WDIV:
            begin
                if (div_rsp.done)
                begin
                    w_reg <= div_rsp.quotient[31:0];
                end
            end
            S_F_WMUL:
            begin
                case (prev_step)
                    4'd0: accx_reg <= accx_reg + mul_p_reg;
                    4'd1: accy_reg <= accy_reg + mul_p_reg;
                    default: ;
                endcase
            end
            S_F_FIN:
            begin
                resx_reg <= round39(accx_reg);
                resy_reg <= round39(accy_reg);
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
